// ===== sv/rpj_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Disparity reprojection package
// Shared widths, register indexes and the sideband struct that travels
// alongside each item through the divider pipeline.
// ============================================================================
package rpj_pkg;

    // Image map limits. A pixel at or beyond these gives an invalid point.
    localparam int unsigned MAX_COLUMNS = 4096;
    localparam int unsigned MAX_ROWS    = 4096;

    // Datapath widths.
    localparam int unsigned PIX_W  = 12;
    localparam int unsigned Q_W    = 16;
    localparam int unsigned TMAX_W = 17;
    localparam int unsigned COL_W  = 8;
    localparam int unsigned PROD_W = 2 * Q_W;
    localparam int unsigned NUM_W  = PROD_W + 4;
    localparam int unsigned DEN_W  = Q_W;
    localparam int unsigned LANES  = 3;
    localparam int unsigned SAT_W  = 31;
    localparam int unsigned OUT_W  = 32;
    localparam int unsigned SUM_W  = 10;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_FOCAL     = 3'd2,
        REG_BASELINE  = 3'd3,
        REG_THRESH_LO = 3'd4,
        REG_THRESH_HI = 3'd5
    } rpj_reg_idx_t;

    // Divider lanes.
    localparam int unsigned LANE_Z = 0;
    localparam int unsigned LANE_X = 1;
    localparam int unsigned LANE_Y = 2;

    // Reciprocal of three for the intensity mean: floor(sum * 683 / 2048).
    localparam int unsigned RECIP3     = 683;
    localparam int unsigned RECIP3_SHR = 11;

    // Sideband carried with each item.
    typedef struct packed {
        logic             ok;
        logic             neg_x;
        logic             neg_y;
        logic [COL_W-1:0] intensity;
    } rpj_tag_t;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [Q_W-1:0]    ctr_col;
        logic [Q_W-1:0]    ctr_row;
        logic [Q_W-1:0]    focal;
        logic [Q_W-1:0]    baseline;
        logic [Q_W-1:0]    thresh_lo;
        logic [TMAX_W-1:0] thresh_hi;
    } rpj_cfg_t;

endpackage

// ===== sv/disparity_to_point_reprojection.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Disparity to point reprojection
// Turns one stereo pixel per clock, unless stalled, into a 3-D point in Q.4
// millimetres with the mean intensity of its color.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   pixel in | pix_valid / pix_stall      | column row disparity red green blue
//   point out| pt_valid / pt_stall        | valid_res pos_x pos_y depth_z
//            |                            | intensity
//   config   | cfg_valid / cfg_ready      | cfg_index cfg_data
//
// One item per clock unless stalled. Stages: two front stages, one stage per
// quotient bit of the 36-bit dividers, and the output register.
// The whole pipeline advances together; pix_stall is high only while a
// finished point sits in the output register and pt_stall holds it.
// Reset clears all valid bits and loads the register defaults.
// ============================================================================
module disparity_to_point_reprojection
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pix_valid,
    output logic                               pix_stall,
    input  logic [rpj_pkg::PIX_W-1:0]          column,
    input  logic [rpj_pkg::PIX_W-1:0]          row,
    input  logic [rpj_pkg::Q_W-1:0]            disparity,
    input  logic [rpj_pkg::COL_W-1:0]          red,
    input  logic [rpj_pkg::COL_W-1:0]          green,
    input  logic [rpj_pkg::COL_W-1:0]          blue,
    output logic                               pt_valid,
    input  logic                               pt_stall,
    output logic                               valid_res,
    output logic signed [rpj_pkg::OUT_W-1:0]   pos_x,
    output logic signed [rpj_pkg::OUT_W-1:0]   pos_y,
    output logic [rpj_pkg::SAT_W-1:0]          depth_z,
    output logic [rpj_pkg::COL_W-1:0]          intensity,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rpj_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rpj_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rpj_pkg::*;

    rpj_cfg_t         cfg_reg;
    logic             adv;
    logic             f_vld;
    rpj_tag_t         f_tag;
    logic [DEN_W-1:0] f_den;
    logic [NUM_W-1:0] f_num [LANES];
    logic             d_vld;
    rpj_tag_t         d_tag;
    logic [NUM_W-1:0] d_quo [LANES];
    logic [SAT_W-1:0] sat   [LANES];

    logic             pt_valid_reg;
    logic             valid_res_reg;
    logic [OUT_W-1:0] pos_x_reg;
    logic [OUT_W-1:0] pos_y_reg;
    logic [SAT_W-1:0] depth_z_reg;
    logic [COL_W-1:0] intensity_reg;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ctr_col   <= '0;
            cfg_reg.ctr_row   <= '0;
            cfg_reg.focal     <= '0;
            cfg_reg.baseline  <= '0;
            cfg_reg.thresh_lo <= '0;
            cfg_reg.thresh_hi <= {1'b1, {(TMAX_W-1){1'b0}}};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CENTER_X:  cfg_reg.ctr_col   <= cfg_data[Q_W-1:0];
                REG_CENTER_Y:  cfg_reg.ctr_row   <= cfg_data[Q_W-1:0];
                REG_FOCAL:     cfg_reg.focal     <= cfg_data[Q_W-1:0];
                REG_BASELINE:  cfg_reg.baseline  <= cfg_data[Q_W-1:0];
                REG_THRESH_LO: cfg_reg.thresh_lo <= cfg_data[Q_W-1:0];
                REG_THRESH_HI: cfg_reg.thresh_hi <= cfg_data;
                default:       ;
            endcase
        end
    end

    // The pipeline moves unless a finished point is held at the output.
    assign adv       = !pt_valid_reg || !pt_stall;
    assign pix_stall = !adv;

    rpj_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .cfg       (cfg_reg),
        .in_vld    (pix_valid),
        .column    (column),
        .row       (row),
        .disparity (disparity),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_vld   (f_vld),
        .out_tag   (f_tag),
        .out_den   (f_den),
        .out_num   (f_num)
    );

    rpj_div_pipe u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (f_vld),
        .in_tag  (f_tag),
        .in_den  (f_den),
        .in_num  (f_num),
        .out_vld (d_vld),
        .out_tag (d_tag),
        .out_quo (d_quo)
    );

    // Saturate each quotient to 31 bits.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            sat[i] = (|d_quo[i][NUM_W-1:SAT_W]) ? {SAT_W{1'b1}} : d_quo[i][SAT_W-1:0];
        end
    end

    // Output valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pt_valid_reg <= 1'b0;
        else if (adv)
            pt_valid_reg <= d_vld;
    end

    // Output payload: apply signs; an invalid pixel gives a zero point.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            valid_res_reg <= d_tag.ok;
            if (d_tag.ok)
            begin
                pos_x_reg     <= d_tag.neg_x ? (OUT_W'(0) - {1'b0, sat[LANE_X]})
                                             : {1'b0, sat[LANE_X]};
                pos_y_reg     <= d_tag.neg_y ? (OUT_W'(0) - {1'b0, sat[LANE_Y]})
                                             : {1'b0, sat[LANE_Y]};
                depth_z_reg   <= sat[LANE_Z];
                intensity_reg <= d_tag.intensity;
            end
            else
            begin
                pos_x_reg     <= '0;
                pos_y_reg     <= '0;
                depth_z_reg   <= '0;
                intensity_reg <= '0;
            end
        end
    end

    assign pt_valid  = pt_valid_reg;
    assign valid_res = valid_res_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign depth_z   = depth_z_reg;
    assign intensity = intensity_reg;

endmodule

// ===== sv/rpj_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Reprojection front end
// Two register stages: validity check and offset magnitudes, then the
// baseline products and the intensity mean.
// ============================================================================
module rpj_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  rpj_pkg::rpj_cfg_t              cfg,
    input  logic                           in_vld,
    input  logic [rpj_pkg::PIX_W-1:0]      column,
    input  logic [rpj_pkg::PIX_W-1:0]      row,
    input  logic [rpj_pkg::Q_W-1:0]        disparity,
    input  logic [rpj_pkg::COL_W-1:0]      red,
    input  logic [rpj_pkg::COL_W-1:0]      green,
    input  logic [rpj_pkg::COL_W-1:0]      blue,
    output logic                           out_vld,
    output rpj_pkg::rpj_tag_t              out_tag,
    output logic [rpj_pkg::DEN_W-1:0]      out_den,
    output logic [rpj_pkg::NUM_W-1:0]      out_num [rpj_pkg::LANES]
);
    import rpj_pkg::*;

    // Stage A signals.
    logic             a_ok;
    logic             a_neg_x;
    logic             a_neg_y;
    logic [Q_W-1:0]   a_px;
    logic [Q_W-1:0]   a_py;
    logic [Q_W-1:0]   a_mag_x;
    logic [Q_W-1:0]   a_mag_y;

    logic             a_vld_reg;
    logic             a_ok_reg;
    logic             a_neg_x_reg;
    logic             a_neg_y_reg;
    logic [Q_W-1:0]   a_mag_x_reg;
    logic [Q_W-1:0]   a_mag_y_reg;
    logic [Q_W-1:0]   a_den_reg;
    logic [SUM_W-1:0] a_sum_reg;

    // Stage B signals.
    logic [SUM_W+SUM_W-1:0] b_scaled;
    logic                   b_vld_reg;
    rpj_tag_t               b_tag_reg;
    logic [DEN_W-1:0]       b_den_reg;
    logic [PROD_W-1:0]      b_prod_reg [LANES];

    // Pixel position in Q12.4 and the signed offset from the principal point.
    always_comb
    begin
        a_px    = {column, 4'b0000};
        a_py    = {row, 4'b0000};
        a_neg_x = a_px < cfg.ctr_col;
        a_neg_y = a_py < cfg.ctr_row;
        a_mag_x = a_neg_x ? (cfg.ctr_col - a_px) : (a_px - cfg.ctr_col);
        a_mag_y = a_neg_y ? (cfg.ctr_row - a_py) : (a_py - cfg.ctr_row);
        a_ok    = (cfg.thresh_lo < disparity)
               && ({1'b0, disparity} < cfg.thresh_hi)
               && ({5'd0, column} < 17'(MAX_COLUMNS))
               && ({5'd0, row} < 17'(MAX_ROWS));
    end

    // Stage A valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= in_vld;
    end

    // Stage A payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ok_reg    <= a_ok;
            a_neg_x_reg <= a_neg_x;
            a_neg_y_reg <= a_neg_y;
            a_mag_x_reg <= a_mag_x;
            a_mag_y_reg <= a_mag_y;
            a_den_reg   <= disparity;
            a_sum_reg   <= SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
        end
    end

    // Divide the color sum by three through its reciprocal.
    assign b_scaled = a_sum_reg * SUM_W'(RECIP3);

    // Stage B valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (en)
            b_vld_reg <= a_vld_reg;
    end

    // Stage B payload: one 16 by 16 product per lane.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_tag_reg.ok        <= a_ok_reg;
            b_tag_reg.neg_x     <= a_neg_x_reg;
            b_tag_reg.neg_y     <= a_neg_y_reg;
            b_tag_reg.intensity <= b_scaled[RECIP3_SHR +: COL_W];
            b_den_reg           <= a_den_reg;
            b_prod_reg[LANE_Z]  <= cfg.focal * cfg.baseline;
            b_prod_reg[LANE_X]  <= a_mag_x_reg * cfg.baseline;
            b_prod_reg[LANE_Y]  <= a_mag_y_reg * cfg.baseline;
        end
    end

    // Numerators carry the extra factor of sixteen for Q.4 output.
    assign out_vld = b_vld_reg;
    assign out_tag = b_tag_reg;
    assign out_den = b_den_reg;
    assign out_num[LANE_Z] = {b_prod_reg[LANE_Z], 4'b0000};
    assign out_num[LANE_X] = {b_prod_reg[LANE_X], 4'b0000};
    assign out_num[LANE_Y] = {b_prod_reg[LANE_Y], 4'b0000};

endmodule

// ===== sv/rpj_div_pipe.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Pipelined restoring divider
// Three lanes share one divisor; each register stage resolves one quotient
// bit of every lane. The item's sideband and valid bit travel alongside.
// ============================================================================
module rpj_div_pipe
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  rpj_pkg::rpj_tag_t             in_tag,
    input  logic [rpj_pkg::DEN_W-1:0]     in_den,
    input  logic [rpj_pkg::NUM_W-1:0]     in_num [rpj_pkg::LANES],
    output logic                          out_vld,
    output rpj_pkg::rpj_tag_t             out_tag,
    output logic [rpj_pkg::NUM_W-1:0]     out_quo [rpj_pkg::LANES]
);
    import rpj_pkg::*;

    // Each stage keeps its own registers; stage s holds the state after
    // s+1 quotient bits.
    genvar s;
    genvar j;
    generate
        for (s = 0; s < NUM_W; s++)
        begin : g_stage
            logic             vld_reg;
            rpj_tag_t         tag_reg;
            logic [DEN_W-1:0] den_reg;
            logic             src_vld;
            rpj_tag_t         src_tag;
            logic [DEN_W-1:0] src_den;
            logic [DEN_W-1:0] src_rem  [LANES];
            logic [NUM_W-1:0] src_work [LANES];

            // The first stage starts from the numerator with a zero remainder.
            if (s == 0)
            begin : g_first
                assign src_vld = in_vld;
                assign src_tag = in_tag;
                assign src_den = in_den;
                for (j = 0; j < LANES; j++)
                begin : g_lane
                    assign src_rem[j]  = '0;
                    assign src_work[j] = in_num[j];
                end
            end
            else
            begin : g_next
                assign src_vld = g_stage[s-1].vld_reg;
                assign src_tag = g_stage[s-1].tag_reg;
                assign src_den = g_stage[s-1].den_reg;
                for (j = 0; j < LANES; j++)
                begin : g_lane
                    assign src_rem[j]  = g_stage[s-1].g_sub[j].rem_reg;
                    assign src_work[j] = g_stage[s-1].g_sub[j].work_reg;
                end
            end

            // Valid bit of this stage.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg <= 1'b0;
                else if (en)
                    vld_reg <= src_vld;
            end

            // Sideband and divisor move with the item.
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tag_reg <= src_tag;
                    den_reg <= src_den;
                end
            end

            // One trial subtraction per lane; quotient bits shift in below.
            for (j = 0; j < LANES; j++)
            begin : g_sub
                logic [DEN_W:0]   trial;
                logic [DEN_W:0]   diff;
                logic             ge;
                logic [DEN_W-1:0] rem_reg;
                logic [NUM_W-1:0] work_reg;

                assign trial = {src_rem[j], src_work[j][NUM_W-1]};
                assign diff  = trial - {1'b0, src_den};
                assign ge    = trial >= {1'b0, src_den};

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                        work_reg <= {src_work[j][NUM_W-2:0], ge};
                    end
                end
            end
        end
    endgenerate

    assign out_vld = g_stage[NUM_W-1].vld_reg;
    assign out_tag = g_stage[NUM_W-1].tag_reg;
    generate
        for (j = 0; j < LANES; j++)
        begin : g_out
            assign out_quo[j] = g_stage[NUM_W-1].g_sub[j].work_reg;
        end
    endgenerate

endmodule

// ===== sv/rpj_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Reprojection port checker
// Watches the top level's ports and flags handshake or result slips.
// ============================================================================
module rpj_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pix_stall,
    input  logic        pt_valid,
    input  logic        pt_stall,
    input  logic        valid_res,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [30:0] depth_z,
    input  logic [7:0]  intensity,
    input  logic        cfg_ready
);

    // An invalid point carries all-zero fields.
    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_valid && !valid_res) |-> (pos_x == 32'd0 && pos_y == 32'd0
                                      && depth_z == 31'd0 && intensity == 8'd0))
        else $error("invalid point with nonzero fields");

    // The input side stalls only while a finished point is held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (pt_valid && pt_stall))
        else $error("input stalled without a held point");

    // A held point stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_valid && pt_stall) |=> (pt_valid && $stable(pos_x) && $stable(depth_z)))
        else $error("held point changed");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind disparity_to_point_reprojection rpj_checker u_rpj_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_stall (pix_stall),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .valid_res (valid_res),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .depth_z   (depth_z),
    .intensity (intensity),
    .cfg_ready (cfg_ready)
);
